// ----- design/mts_pkg.sv -----
// Package for the Morse timing statistics block: character codes, field widths,
// sequencer state type and the sample-update descriptor.
// No dependencies.
package mts_pkg;

	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [15:0] WEIGHT_RESET = 16'd58982;

	localparam int SYMBOL_W     = 8;
	localparam int WEIGHT_W     = 16;
	localparam int COUNT_OUT_W  = 32;
	localparam int MEAN_MARK_W  = 18;
	localparam int VAR_MARK_W   = 19;
	localparam int MEAN_SPACE_W = 19;
	localparam int VAR_SPACE_W  = 22;

	// sample lengths in dit units
	localparam logic [2:0] LEN_DIT        = 3'd1;
	localparam logic [2:0] LEN_DAH        = 3'd3;
	localparam logic [2:0] LEN_ELEM_GAP   = 3'd1;
	localparam logic [2:0] LEN_LETTER_GAP = 3'd3;
	localparam logic [2:0] LEN_WORD_GAP   = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_VAR,
		S_MUL_MEAN,
		S_MEAN_UPD,
		S_MUL_SQ,
		S_SQ_RND,
		S_MUL_VS,
		S_VAR_UPD,
		S_DONE
	} state_t;

	typedef enum logic {
		KIND_MARK,
		KIND_SPACE
	} sample_kind_t;

	typedef struct packed {
		sample_kind_t kind;
		logic [2:0]   len;
	} sample_op_t;

endpackage

// ----- design/mts_if.sv -----
// Valid/ready channel interfaces of the Morse timing statistics block:
// symbol input, statistics output and weight write channel. Uses mts_pkg.
interface mts_in_if;
	import mts_pkg::*;
	logic                valid;
	logic                ready;
	logic [SYMBOL_W-1:0] symbol;
	logic                last_of_string;

	modport source (output valid, output symbol, output last_of_string, input ready);
	modport sink (input valid, input symbol, input last_of_string, output ready);
endinterface

interface mts_out_if;
	import mts_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [COUNT_OUT_W-1:0]  dit_count;
	logic [COUNT_OUT_W-1:0]  dah_count;
	logic [COUNT_OUT_W-1:0]  element_gap_count;
	logic [COUNT_OUT_W-1:0]  letter_gap_count;
	logic [COUNT_OUT_W-1:0]  word_gap_count;
	logic [MEAN_MARK_W-1:0]  mean_mark;
	logic [VAR_MARK_W-1:0]   var_mark;
	logic [MEAN_SPACE_W-1:0] mean_space;
	logic [VAR_SPACE_W-1:0]  var_space;

	modport source (
		output valid, output dit_count, output dah_count, output element_gap_count,
		output letter_gap_count, output word_gap_count, output mean_mark,
		output var_mark, output mean_space, output var_space, input ready
	);
	modport sink (
		input valid, input dit_count, input dah_count, input element_gap_count,
		input letter_gap_count, input word_gap_count, input mean_mark,
		input var_mark, input mean_space, input var_space, output ready
	);
endinterface

interface mts_cfg_if;
	import mts_pkg::*;
	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/morse_timing_statistics.sv -----
// Morse timing statistics: element/letter/word gap counting and weighted
// mean/variance tracking on one shared multiplier. Uses mts_pkg and mts_if.
//
// channel   modport  carries                                   transaction
// symbols   sink     symbol, last_of_string                    one character
// stats     source   five counts, mark/space means, variances  one result per character
// cfg       sink     data (history weight, Q0.16)              one weight write
//
// Each weighted update runs 7 steps, S_MUL_VAR to S_VAR_UPD, through the single registered
// multiplier, a second update following the first; with none, S_IDLE goes straight to S_DONE.
// The block takes no character from acceptance until its result is loaded
// into the output register; it then accepts the next one while that result waits.
// A finished result holds in S_DONE while the previous one is not yet taken.
// arst_n restores all counts, means, variances, gap flags and the default weight.
module morse_timing_statistics #(
	parameter int COUNT_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input logic       clk,
	input logic       arst_n,
	mts_cfg_if.sink   cfg,
	mts_in_if.sink    symbols,
	mts_out_if.source stats
);
	import mts_pkg::*;

	localparam int MUL_W  = FRAC_BITS + 6;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MM_W   = FRAC_BITS + 2;
	localparam int MV_W   = FRAC_BITS + 3;
	localparam int SM_W   = FRAC_BITS + 3;
	localparam int SV_W   = FRAC_BITS + 6;
	localparam int DM_W   = FRAC_BITS + 4;
	localparam int W_SHL  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int W_SHR  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [FRAC_BITS:0]    ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SUM_W-1:0] HALF_Q         = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic [SUM_W-1:0] MARK_MEAN_MAX  = SUM_W'(3) << FRAC_BITS;
	localparam logic [SUM_W-1:0] MARK_VAR_MAX   = SUM_W'(4) << FRAC_BITS;
	localparam logic [SUM_W-1:0] SPACE_MEAN_MAX = SUM_W'(7) << FRAC_BITS;
	localparam logic [SUM_W-1:0] SPACE_VAR_MAX  = SUM_W'(36) << FRAC_BITS;

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
	                                                 input logic [1:0] inc);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS + 1)'(inc);
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	state_t state_q, state_d;

	logic [WEIGHT_W-1:0]   weight_q;
	logic [COUNT_BITS-1:0] dit_cnt_q, dah_cnt_q, eg_cnt_q, lg_cnt_q, wg_cnt_q;
	logic [MM_W-1:0]       mark_mean_q;
	logic [MV_W-1:0]       mark_var_q;
	logic [SM_W-1:0]       space_mean_q;
	logic [SV_W-1:0]       space_var_q;
	logic                  prev_elem_q, gap_pend_q, space_run_q;

	sample_op_t            op_q, op_next_q;
	logic                  second_q;
	logic [PROD_W-1:0]     prod_q, acc_q;
	logic [MUL_W-1:0]      diff_q, sq_q;

	logic                  out_valid_q;
	logic [COUNT_OUT_W-1:0] out_dit_q, out_dah_q, out_eg_q, out_lg_q, out_wg_q;
	logic [MEAN_MARK_W-1:0]  out_mean_mark_q;
	logic [VAR_MARK_W-1:0]   out_var_mark_q;
	logic [MEAN_SPACE_W-1:0] out_mean_space_q;
	logic [VAR_SPACE_W-1:0]  out_var_space_q;

	logic in_ready, in_accept, out_load;
	logic [MUL_W-1:0] mul_a, mul_b;

	// ---------------------------------------------------------------- weight
	logic [31:0]          w_ext;
	logic [FRAC_BITS-1:0] w;
	logic [FRAC_BITS:0]   omw;

	assign w_ext = (32'(weight_q) << W_SHL) >> W_SHR;
	assign w     = w_ext[FRAC_BITS-1:0];
	assign omw   = ONE_Q - {1'b0, w};

	// ---------------------------------------------------------------- character decode
	logic       is_dot, is_dash, is_space, is_elem;
	logic       prev_d, gap_d, run_d, consumed;
	logic       op_a_v, op_b_v, op_c_v;
	sample_op_t op_a, op_b, op_c, op0, op1;
	logic       has0, has1;
	logic       inc_dit, inc_dah, inc_eg, inc_wg;
	logic [1:0] inc_lg;

	assign is_dot   = (symbols.symbol == CHAR_DOT);
	assign is_dash  = (symbols.symbol == CHAR_DASH);
	assign is_space = (symbols.symbol == CHAR_SPACE);
	assign is_elem  = is_dot || is_dash;

	always_comb begin
		prev_d   = prev_elem_q;
		gap_d    = gap_pend_q;
		run_d    = space_run_q;
		consumed = 1'b0;
		op_a_v   = 1'b0;
		op_b_v   = 1'b0;
		op_c_v   = 1'b0;
		op_a     = '{kind: KIND_SPACE, len: LEN_ELEM_GAP};
		op_b     = '{kind: KIND_MARK, len: LEN_DIT};
		op_c     = '{kind: KIND_SPACE, len: LEN_LETTER_GAP};
		inc_dit  = 1'b0;
		inc_dah  = 1'b0;
		inc_eg   = 1'b0;
		inc_wg   = 1'b0;
		inc_lg   = 2'd0;

		// settle what the previous character left open
		if (prev_elem_q) begin
			if (is_elem) begin
				inc_eg = 1'b1;
				op_a_v = 1'b1;
			end
			prev_d = 1'b0;
		end else if (gap_pend_q) begin
			gap_d  = 1'b0;
			op_a_v = 1'b1;
			if (is_space) begin
				inc_wg   = 1'b1;
				op_a.len = LEN_WORD_GAP;
				run_d    = 1'b1;
				consumed = 1'b1;
			end else begin
				inc_lg   = 2'd1;
				op_a.len = LEN_LETTER_GAP;
			end
		end else if (space_run_q) begin
			if (is_space)
				consumed = 1'b1;
			else
				run_d = 1'b0;
		end

		if (!consumed) begin
			if (is_dot) begin
				inc_dit = 1'b1;
				op_b_v  = 1'b1;
				prev_d  = 1'b1;
			end else if (is_dash) begin
				inc_dah  = 1'b1;
				op_b_v   = 1'b1;
				op_b.len = LEN_DAH;
				prev_d   = 1'b1;
			end else begin
				gap_d = 1'b1;
			end
		end

		if (symbols.last_of_string) begin
			if (gap_d) begin
				inc_lg = inc_lg + 2'd1;
				op_c_v = 1'b1;
			end
			prev_d = 1'b0;
			gap_d  = 1'b0;
			run_d  = 1'b0;
		end

		// at most two updates per character; keep them in model order
		op0  = op_a_v ? op_a : (op_b_v ? op_b : op_c);
		op1  = (op_a_v && op_b_v) ? op_b : op_c;
		has0 = op_a_v || op_b_v || op_c_v;
		has1 = (op_a_v && op_b_v) || (op_a_v && op_c_v) || (op_b_v && op_c_v);
	end

	// ---------------------------------------------------------------- update arithmetic
	logic [DM_W-1:0]  omw_x, dmul;
	logic [SUM_W-1:0] mean_max, var_max;
	logic [SUM_W-1:0] mean_sum, mean_sh, mean_cl;
	logic [SUM_W-1:0] var_sum, var_sh, var_cl;
	logic [SUM_W-1:0] sq_sum;
	logic [MUL_W-1:0] mean_new, dq, diff, sq_new;
	logic [MUL_W-1:0] mean_sel, var_sel;

	assign omw_x = DM_W'(omw);

	always_comb begin
		case (op_q.len)
			LEN_DAH:      dmul = (omw_x << 1) + omw_x;
			LEN_WORD_GAP: dmul = (omw_x << 3) - omw_x;
			default:      dmul = omw_x;
		endcase
	end

	assign mean_max = (op_q.kind == KIND_SPACE) ? SPACE_MEAN_MAX : MARK_MEAN_MAX;
	assign var_max  = (op_q.kind == KIND_SPACE) ? SPACE_VAR_MAX : MARK_VAR_MAX;
	assign mean_sel = (op_q.kind == KIND_SPACE) ? MUL_W'(space_mean_q) : MUL_W'(mark_mean_q);
	assign var_sel  = (op_q.kind == KIND_SPACE) ? MUL_W'(space_var_q) : MUL_W'(mark_var_q);

	assign mean_sum = SUM_W'(prod_q) + (SUM_W'(dmul) << FRAC_BITS) + HALF_Q;
	assign mean_sh  = mean_sum >> FRAC_BITS;
	assign mean_cl  = (mean_sh > mean_max) ? mean_max : mean_sh;
	assign mean_new = MUL_W'(mean_cl);
	assign dq       = MUL_W'(op_q.len) << FRAC_BITS;
	assign diff     = (mean_new >= dq) ? mean_new - dq : dq - mean_new;

	assign sq_sum   = SUM_W'(prod_q) + HALF_Q;
	assign sq_new   = MUL_W'(sq_sum >> FRAC_BITS);

	assign var_sum  = SUM_W'(acc_q) + SUM_W'(prod_q) + HALF_Q;
	assign var_sh   = var_sum >> FRAC_BITS;
	assign var_cl   = (var_sh > var_max) ? var_max : var_sh;

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_accept) state_d = has0 ? S_MUL_VAR : S_DONE;
			S_MUL_VAR:  state_d = S_MUL_MEAN;
			S_MUL_MEAN: state_d = S_MEAN_UPD;
			S_MEAN_UPD: state_d = S_MUL_SQ;
			S_MUL_SQ:   state_d = S_SQ_RND;
			S_SQ_RND:   state_d = S_MUL_VS;
			S_MUL_VS:   state_d = S_VAR_UPD;
			S_VAR_UPD:  state_d = second_q ? S_MUL_VAR : S_DONE;
			S_DONE:     if (out_load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_MUL_VAR: begin
				mul_a = var_sel;
				mul_b = MUL_W'(w);
			end
			S_MUL_MEAN: begin
				mul_a = mean_sel;
				mul_b = MUL_W'(w);
			end
			S_MUL_SQ: begin
				mul_a = diff_q;
				mul_b = diff_q;
			end
			S_MUL_VS: begin
				mul_a = sq_q;
				mul_b = MUL_W'(omw);
			end
			S_DONE: out_load = !out_valid_q || stats.ready;
			default: ;
		endcase
	end

	assign in_accept     = symbols.valid && in_ready;
	assign symbols.ready = in_ready;
	assign cfg.ready     = 1'b1;

	// ---------------------------------------------------------------- state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			weight_q     <= WEIGHT_RESET;
			dit_cnt_q    <= '0;
			dah_cnt_q    <= '0;
			eg_cnt_q     <= '0;
			lg_cnt_q     <= '0;
			wg_cnt_q     <= '0;
			mark_mean_q  <= MM_W'(2) << FRAC_BITS;
			mark_var_q   <= MV_W'(1) << FRAC_BITS;
			space_mean_q <= SM_W'(2) << FRAC_BITS;
			space_var_q  <= SV_W'(3) << FRAC_BITS;
			prev_elem_q  <= 1'b0;
			gap_pend_q   <= 1'b0;
			space_run_q  <= 1'b0;
			second_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				weight_q <= cfg.data;
			if (in_accept) begin
				dit_cnt_q   <= sat_add(dit_cnt_q, {1'b0, inc_dit});
				dah_cnt_q   <= sat_add(dah_cnt_q, {1'b0, inc_dah});
				eg_cnt_q    <= sat_add(eg_cnt_q, {1'b0, inc_eg});
				lg_cnt_q    <= sat_add(lg_cnt_q, inc_lg);
				wg_cnt_q    <= sat_add(wg_cnt_q, {1'b0, inc_wg});
				prev_elem_q <= prev_d;
				gap_pend_q  <= gap_d;
				space_run_q <= run_d;
				second_q    <= has1;
			end
			if (state_q == S_MEAN_UPD) begin
				if (op_q.kind == KIND_SPACE)
					space_mean_q <= SM_W'(mean_cl);
				else
					mark_mean_q <= MM_W'(mean_cl);
			end
			if (state_q == S_VAR_UPD) begin
				if (op_q.kind == KIND_SPACE)
					space_var_q <= SV_W'(var_cl);
				else
					mark_var_q <= MV_W'(var_cl);
				second_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (stats.ready)
				out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= op0;
			op_next_q <= op1;
		end
		if (state_q == S_VAR_UPD && second_q)
			op_q <= op_next_q;
		case (state_q)
			S_MUL_VAR:  prod_q <= mul_a * mul_b;
			S_MUL_MEAN: begin
				acc_q  <= prod_q;
				prod_q <= mul_a * mul_b;
			end
			S_MEAN_UPD: diff_q <= diff;
			S_MUL_SQ:   prod_q <= mul_a * mul_b;
			S_SQ_RND:   sq_q   <= sq_new;
			S_MUL_VS:   prod_q <= mul_a * mul_b;
			default: ;
		endcase
		if (out_load) begin
			out_dit_q        <= COUNT_OUT_W'(dit_cnt_q);
			out_dah_q        <= COUNT_OUT_W'(dah_cnt_q);
			out_eg_q         <= COUNT_OUT_W'(eg_cnt_q);
			out_lg_q         <= COUNT_OUT_W'(lg_cnt_q);
			out_wg_q         <= COUNT_OUT_W'(wg_cnt_q);
			out_mean_mark_q  <= MEAN_MARK_W'(mark_mean_q);
			out_var_mark_q   <= VAR_MARK_W'(mark_var_q);
			out_mean_space_q <= MEAN_SPACE_W'(space_mean_q);
			out_var_space_q  <= VAR_SPACE_W'(space_var_q);
		end
	end

	assign stats.valid             = out_valid_q;
	assign stats.dit_count         = out_dit_q;
	assign stats.dah_count         = out_dah_q;
	assign stats.element_gap_count = out_eg_q;
	assign stats.letter_gap_count  = out_lg_q;
	assign stats.word_gap_count    = out_wg_q;
	assign stats.mean_mark         = out_mean_mark_q;
	assign stats.var_mark          = out_var_mark_q;
	assign stats.mean_space        = out_mean_space_q;
	assign stats.var_space         = out_var_space_q;

	// ---------------------------------------------------------------- assertions
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !stats.ready) |=> (state_q == S_DONE))
		else $error("finished result moved on while output stalled");

	a_means_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(mark_mean_q) <= MARK_MEAN_MAX) && (SUM_W'(space_mean_q) <= SPACE_MEAN_MAX))
		else $error("weighted mean out of range");

	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(lg_cnt_q >= $past(lg_cnt_q)) && (dit_cnt_q >= $past(dit_cnt_q)))
		else $error("counter decreased");

	a_string_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && symbols.last_of_string) |=> (!prev_elem_q && !gap_pend_q && !space_run_q))
		else $error("gap state left open after string end");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for morse_timing_statistics: drives characters and weight writes,
// predicts every statistics result and compares it field by field.
// Depends on mts_pkg, mts_if and the block itself.
module tb_top;
	import mts_pkg::*;

	localparam int FRAC = 16;
	localparam bit [63:0] ONE_Q = 64'd1 << FRAC;
	localparam bit [63:0] HALF_Q = 64'd1 << (FRAC - 1);
	localparam bit [63:0] COUNT_MAX = 64'hFFFF_FFFF;
	localparam int SETTLE_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS = 290;

	typedef struct packed {
		logic [COUNT_OUT_W-1:0]  dits;
		logic [COUNT_OUT_W-1:0]  dahs;
		logic [COUNT_OUT_W-1:0]  elem_gaps;
		logic [COUNT_OUT_W-1:0]  letter_gaps;
		logic [COUNT_OUT_W-1:0]  word_gaps;
		logic [MEAN_MARK_W-1:0]  mean_mark;
		logic [VAR_MARK_W-1:0]   var_mark;
		logic [MEAN_SPACE_W-1:0] mean_space;
		logic [VAR_SPACE_W-1:0]  var_space;
	} stats_t;

	class stats_scoreboard;
		bit [WEIGHT_W-1:0] weight;
		bit [63:0] dits, dahs, elem_gaps, letter_gaps, word_gaps;
		bit [63:0] mark_mean, mark_spread, space_mean, space_spread;
		bit prev_mark, gap_open, in_space_run;
		stats_t expected_q[$];
		int unsigned errors;

		function new();
			weight = WEIGHT_RESET;
			dits = 0;
			dahs = 0;
			elem_gaps = 0;
			letter_gaps = 0;
			word_gaps = 0;
			mark_mean = 64'd2 << FRAC;
			mark_spread = 64'd1 << FRAC;
			space_mean = 64'd2 << FRAC;
			space_spread = 64'd3 << FRAC;
			prev_mark = 0;
			gap_open = 0;
			in_space_run = 0;
			errors = 0;
		endfunction

		function void set_weight(bit [WEIGHT_W-1:0] w);
			weight = w;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit [63:0] bumped(bit [63:0] c);
			return (c < COUNT_MAX) ? c + 64'd1 : c;
		endfunction

		// exponentially weighted mean, then variance against the new mean
		function void blend(input bit [63:0] mean_in, input bit [63:0] spread_in,
				input bit [2:0] len, input bit [63:0] mean_max, input bit [63:0] spread_max,
				output bit [63:0] mean_out, output bit [63:0] spread_out);
			bit [63:0] w, dq, mi, si, m, diff, sq, s;
			w = {48'd0, weight};
			dq = {61'd0, len} << FRAC;
			mi = (mean_in > mean_max) ? mean_max : mean_in;
			si = (spread_in > spread_max) ? spread_max : spread_in;
			m = (mi * w + dq * (ONE_Q - w) + HALF_Q) >> FRAC;
			if (m > mean_max)
				m = mean_max;
			diff = (m >= dq) ? m - dq : dq - m;
			sq = (diff * diff + HALF_Q) >> FRAC;
			s = (si * w + sq * (ONE_Q - w) + HALF_Q) >> FRAC;
			if (s > spread_max)
				s = spread_max;
			mean_out = m;
			spread_out = s;
		endfunction

		function void add_mark(bit [2:0] len);
			blend(mark_mean, mark_spread, len, 64'd3 << FRAC, 64'd4 << FRAC,
				mark_mean, mark_spread);
		endfunction

		function void add_space(bit [2:0] len);
			blend(space_mean, space_spread, len, 64'd7 << FRAC, 64'd36 << FRAC,
				space_mean, space_spread);
		endfunction

		function void note_symbol(bit [SYMBOL_W-1:0] s, bit last);
			bit is_mark, swallowed;
			stats_t e;
			is_mark = (s == CHAR_DOT) || (s == CHAR_DASH);
			swallowed = 0;
			if (prev_mark) begin
				if (is_mark) begin
					elem_gaps = bumped(elem_gaps);
					add_space(LEN_ELEM_GAP);
				end
				prev_mark = 0;
			end else if (gap_open) begin
				gap_open = 0;
				if (s == CHAR_SPACE) begin
					word_gaps = bumped(word_gaps);
					add_space(LEN_WORD_GAP);
					in_space_run = 1;
					swallowed = 1;
				end else begin
					letter_gaps = bumped(letter_gaps);
					add_space(LEN_LETTER_GAP);
				end
			end else if (in_space_run) begin
				if (s == CHAR_SPACE)
					swallowed = 1;
				else
					in_space_run = 0;
			end
			if (!swallowed) begin
				if (s == CHAR_DOT) begin
					dits = bumped(dits);
					add_mark(LEN_DIT);
					prev_mark = 1;
				end else if (s == CHAR_DASH) begin
					dahs = bumped(dahs);
					add_mark(LEN_DAH);
					prev_mark = 1;
				end else begin
					gap_open = 1;
				end
			end
			// end of string settles a waiting gap as a letter gap
			if (last) begin
				if (gap_open) begin
					letter_gaps = bumped(letter_gaps);
					add_space(LEN_LETTER_GAP);
				end
				prev_mark = 0;
				gap_open = 0;
				in_space_run = 0;
			end
			e.dits = dits[31:0];
			e.dahs = dahs[31:0];
			e.elem_gaps = elem_gaps[31:0];
			e.letter_gaps = letter_gaps[31:0];
			e.word_gaps = word_gaps[31:0];
			e.mean_mark = mark_mean[MEAN_MARK_W-1:0];
			e.var_mark = mark_spread[VAR_MARK_W-1:0];
			e.mean_space = space_mean[MEAN_SPACE_W-1:0];
			e.var_space = space_spread[VAR_SPACE_W-1:0];
			expected_q.push_back(e);
		endfunction

		function void compare_field(string field, bit [31:0] want, bit [31:0] got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $realtime, field, want, got);
			end
		endfunction

		function void check_stats(stats_t got);
			stats_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, actual %h", $realtime, got);
				return;
			end
			want = expected_q.pop_front();
			compare_field("dit_count", want.dits, got.dits);
			compare_field("dah_count", want.dahs, got.dahs);
			compare_field("element_gap_count", want.elem_gaps, got.elem_gaps);
			compare_field("letter_gap_count", want.letter_gaps, got.letter_gaps);
			compare_field("word_gap_count", want.word_gaps, got.word_gaps);
			compare_field("mean_mark", 32'(want.mean_mark), 32'(got.mean_mark));
			compare_field("var_mark", 32'(want.var_mark), 32'(got.var_mark));
			compare_field("mean_space", 32'(want.mean_space), 32'(got.mean_space));
			compare_field("var_space", 32'(want.var_space), 32'(got.var_space));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mts_in_if  sym_if ();
	mts_out_if stat_if ();
	mts_cfg_if cfg_if ();

	morse_timing_statistics DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.symbols (sym_if),
		.stats   (stat_if)
	);

	stats_scoreboard sb = new();
	int unsigned send_gap_max = 15;
	int unsigned take_gap_max = 15;
	int unsigned quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && sym_if.valid && sym_if.ready)
			sb.note_symbol(sym_if.symbol, sym_if.last_of_string);
	end

	always @(posedge clk) begin
		stats_t got;
		if (arst_n === 1'b1 && stat_if.valid && stat_if.ready) begin
			got.dits = stat_if.dit_count;
			got.dahs = stat_if.dah_count;
			got.elem_gaps = stat_if.element_gap_count;
			got.letter_gaps = stat_if.letter_gap_count;
			got.word_gaps = stat_if.word_gap_count;
			got.mean_mark = stat_if.mean_mark;
			got.var_mark = stat_if.var_mark;
			got.mean_space = stat_if.mean_space;
			got.var_space = stat_if.var_space;
			sb.check_stats(got);
		end
	end

	// watchdog: too long without any transaction on any channel
	always @(posedge clk) begin
		if ((sym_if.valid && sym_if.ready) || (stat_if.valid && stat_if.ready)
				|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stall before each transaction
	initial begin
		int unsigned k;
		stat_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			k = $urandom_range(0, take_gap_max);
			if (k > 0) begin
				stat_if.ready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			stat_if.ready <= 1'b1;
			do @(posedge clk); while (!(stat_if.valid && stat_if.ready));
		end
	end

	task automatic pick_idling();
		int unsigned mode;
		mode = $urandom_range(0, 5);
		send_gap_max = (mode == 1 || mode == 3) ? 0 : 15;
		take_gap_max = (mode == 2 || mode == 3) ? 0 : 15;
	endtask

	// valid is left high after a transaction; it drops only for a random gap before a symbol or in wait_drained
	task automatic send_symbol(bit [SYMBOL_W-1:0] s, bit last);
		int unsigned k;
		k = $urandom_range(0, send_gap_max);
		if (k > 0) begin
			sym_if.valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		sym_if.valid <= 1'b1;
		sym_if.symbol <= s;
		sym_if.last_of_string <= last;
		do @(posedge clk); while (!(sym_if.valid && sym_if.ready));
	endtask

	task automatic wait_drained();
		sym_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_weight(bit [WEIGHT_W-1:0] w);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= w;
		do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
		cfg_if.valid <= 1'b0;
		sb.set_weight(w);
	endtask

	function automatic bit [7:0] gap_char();
		bit [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CHAR_DOT || c == CHAR_DASH);
		return c;
	endfunction

	function automatic bit [7:0] noise_char();
		case ($urandom_range(0, 3))
			0: return CHAR_DOT;
			1: return CHAR_DASH;
			2: return CHAR_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly well-formed strings of words and letters, with some raw noise
	task automatic send_random(int unsigned n);
		int unsigned sent, words, letters, elems, spaces;
		bit [7:0] chars[$];
		sent = 0;
		while (sent < n) begin
			if (sent % 60 == 0)
				pick_idling();
			chars.delete();
			if ($urandom_range(0, 9) < 7) begin
				words = $urandom_range(1, 4);
				for (int wd = 0; wd < words; wd++) begin
					if (wd > 0) begin
						spaces = $urandom_range(2, 5);
						chars.push_back(($urandom_range(0, 3) == 0) ? gap_char() : CHAR_SPACE);
						for (int i = 1; i < spaces; i++)
							chars.push_back(CHAR_SPACE);
					end
					letters = $urandom_range(1, 5);
					for (int lt = 0; lt < letters; lt++) begin
						if (lt > 0)
							chars.push_back(($urandom_range(0, 4) == 0) ? gap_char() : CHAR_SPACE);
						elems = $urandom_range(1, 5);
						for (int el = 0; el < elems; el++)
							chars.push_back($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT);
					end
				end
				case ($urandom_range(0, 5))
					0: chars.push_back(gap_char());
					1: repeat ($urandom_range(2, 3)) chars.push_back(CHAR_SPACE);
					default: ;
				endcase
				foreach (chars[i])
					send_symbol(chars[i], i == chars.size() - 1);
			end else begin
				repeat ($urandom_range(1, 12)) chars.push_back(noise_char());
				foreach (chars[i])
					send_symbol(chars[i], $urandom_range(0, 3) == 0);
			end
			sent += chars.size();
		end
	endtask

	task automatic send_directed();
		// element gaps, then an element closing the string
		send_symbol(CHAR_DOT, 0);
		send_symbol(CHAR_DASH, 0);
		send_symbol(CHAR_DOT, 1);
		// letter gap on an odd gap character, gap character at string end
		send_symbol(CHAR_DASH, 0);
		send_symbol(8'h78, 0);
		send_symbol(CHAR_DOT, 0);
		send_symbol(8'hFF, 1);
		// word gap, run of spaces absorbed, mark after the run, lone space at end
		send_symbol(CHAR_DOT, 0);
		send_symbol(CHAR_SPACE, 0);
		send_symbol(CHAR_SPACE, 0);
		send_symbol(CHAR_SPACE, 0);
		send_symbol(CHAR_DASH, 0);
		send_symbol(CHAR_SPACE, 1);
		// word gap completed by the flagged space
		send_symbol(8'h00, 0);
		send_symbol(CHAR_SPACE, 1);
		// space run ended by a non-space gap character at string end
		send_symbol(CHAR_SPACE, 0);
		send_symbol(CHAR_SPACE, 0);
		send_symbol(8'h61, 1);
		// no flag between strings: continues as one string
		send_symbol(CHAR_DASH, 0);
		send_symbol(CHAR_DASH, 0);
		send_symbol(CHAR_SPACE, 0);
		send_symbol(CHAR_DOT, 1);
	endtask

	initial begin
		arst_n <= 1'b0;
		sym_if.valid <= 1'b0;
		sym_if.symbol <= '0;
		sym_if.last_of_string <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		send_random(PHASE_ITEMS);

		write_weight(16'd0);
		send_directed();
		send_random(PHASE_ITEMS);

		write_weight(16'hFFFF);
		send_random(PHASE_ITEMS / 2);
		wait_drained();
		send_random(PHASE_ITEMS / 2);

		write_weight(16'($urandom_range(2, 65534)));
		send_random(PHASE_ITEMS);

		write_weight(16'd1);
		send_random(PHASE_ITEMS);

		write_weight(16'h8000);
		send_random(PHASE_ITEMS);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
